/* rtl/core/mtd_pkg.sv */
// Shared types, character constants and lookup functions for the MIME transfer decoder.
// Used by mtd_front, mtd_back and the top level; depends on nothing else.
package mtd_pkg;

  typedef enum logic [1:0] {
    MODE_COPY = 2'd0,
    MODE_QP   = 2'd1,
    MODE_B64  = 2'd2,
    MODE_OFF  = 2'd3
  } mode_e;

  localparam logic [7:0] EQ_CHAR = 8'h3D;
  localparam logic [7:0] LF_CHAR = 8'h0A;
  localparam logic [7:0] SP_CHAR = 8'h20;
  localparam logic [5:0] B64_PLUS = 6'd62;
  localparam logic [5:0] B64_SLASH = 6'd63;

  // Fixed part of one job handed from the front to the back. The bytes in
  // pre go out first, then any held whitespace, then post.
  typedef struct packed {
    logic [2:0][7:0] pre;
    logic [1:0]      pre_n;
    logic [7:0]      post;
    logic            post_valid;
    logic            last;
  } job_head_t;

  function automatic logic is_space(logic [7:0] c);
    return (c == SP_CHAR) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // Non-hex characters count as zero.
  function automatic logic [3:0] hex_value(logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) d = c - 8'h30;
    else if (c >= 8'h61 && c <= 8'h66) d = c - 8'h57;
    else if (c >= 8'h41 && c <= 8'h46) d = c - 8'h37;
    return d[3:0];
  endfunction

  // Bit 6 set means the character is not part of the alphabet.
  function automatic logic [6:0] b64_value(logic [7:0] c);
    logic [7:0] d;
    logic       bad;
    d   = 8'h00;
    bad = 1'b0;
    if (c >= 8'h41 && c <= 8'h5A) d = c - 8'h41;
    else if (c >= 8'h61 && c <= 8'h7A) d = c - 8'h47;
    else if (c >= 8'h30 && c <= 8'h39) d = c + 8'h04;
    else if (c == 8'h2B) d = {2'b00, B64_PLUS};
    else if (c == 8'h2F) d = {2'b00, B64_SLASH};
    else bad = 1'b1;
    return {bad, d[5:0]};
  endfunction

endpackage

/* rtl/core/mtd_front.sv */
// Front part of the MIME transfer decoder: accepts encoded bytes, keeps the
// escape and base64 group state, and turns each byte that yields output or ends a message into a job. Uses mtd_pkg.
module mtd_front #(
  parameter int unsigned SPACE_DEPTH = 8,
  localparam int unsigned CntW  = $clog2(SPACE_DEPTH + 1),
  localparam int unsigned AddrW = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mtd_pkg::mode_e              mode_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  in_byte_i,
  input  logic                        in_last_i,
  input  logic                        queue_full_i,
  output logic                        push_o,
  output mtd_pkg::job_head_t          head_o,
  output logic [SPACE_DEPTH-1:0][7:0] spaces_o,
  output logic [CntW-1:0]             space_n_o
);

  typedef enum logic [1:0] {
    PH_NONE  = 2'd0,
    PH_EQ    = 2'd1,
    PH_DIGIT = 2'd2,
    PH_SPACE = 2'd3
  } phase_e;

  phase_e                      phase_q, phase_d;
  logic [23:0]                 group_bits_q, group_bits_d;
  logic [1:0]                  group_count_q, group_count_d;
  logic [1:0]                  pad_count_q, pad_count_d;
  logic                        pad_done_q, pad_done_d;
  logic [7:0]                  first_q, first_d;
  logic                        second_q, second_d;
  logic [CntW-1:0]             space_cnt_q, space_cnt_d;
  logic [SPACE_DEPTH-1:0][7:0] space_q;

  logic                        accept;
  logic                        store_we;
  logic [6:0]                  b64;
  logic                        is_pad;
  logic [5:0]                  sym;
  logic [1:0]                  pad_nx;
  logic [23:0]                 gb_nx;
  mtd_pkg::job_head_t          head;
  logic [CntW-1:0]             space_n;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    phase_d       = phase_q;
    group_bits_d  = group_bits_q;
    group_count_d = group_count_q;
    pad_count_d   = pad_count_q;
    pad_done_d    = pad_done_q;
    first_d       = first_q;
    second_d      = second_q;
    space_cnt_d   = space_cnt_q;
    store_we      = 1'b0;
    head          = '0;
    space_n       = '0;
    b64           = mtd_pkg::b64_value(in_byte_i);
    is_pad        = (in_byte_i == mtd_pkg::EQ_CHAR);
    sym           = is_pad ? 6'd0 : b64[5:0];
    pad_nx        = (is_pad && pad_count_q != 2'd3) ? pad_count_q + 2'd1 : pad_count_q;
    gb_nx         = {group_bits_q[17:0], sym};

    unique case (mode_i)
      mtd_pkg::MODE_COPY: begin
        head.pre[0] = in_byte_i;
        head.pre_n  = 2'd1;
      end
      mtd_pkg::MODE_QP: begin
        unique case (phase_q)
          PH_NONE: begin
            if (is_pad) begin
              phase_d = PH_EQ;
            end else begin
              head.pre[0] = in_byte_i;
              head.pre_n  = 2'd1;
            end
          end
          PH_EQ: begin
            if (in_byte_i == mtd_pkg::LF_CHAR) begin
              phase_d = PH_NONE;
            end else if (mtd_pkg::is_space(in_byte_i)) begin
              first_d     = in_byte_i;
              second_d    = 1'b0;
              space_cnt_d = '0;
              phase_d     = PH_SPACE;
            end else begin
              first_d = in_byte_i;
              phase_d = PH_DIGIT;
            end
          end
          PH_DIGIT: begin
            head.pre[0] = {mtd_pkg::hex_value(first_q), mtd_pkg::hex_value(in_byte_i)};
            head.pre_n  = 2'd1;
            second_d    = 1'b0;
            phase_d     = PH_NONE;
          end
          PH_SPACE: begin
            if (in_byte_i == mtd_pkg::LF_CHAR) begin
              second_d    = 1'b0;
              space_cnt_d = '0;
              phase_d     = PH_NONE;
            end else if (mtd_pkg::is_space(in_byte_i)) begin
              if (!second_q) begin
                second_d = 1'b1;
              end else if (space_cnt_q < CntW'(SPACE_DEPTH)) begin
                store_we    = 1'b1;
                space_cnt_d = space_cnt_q + 1'b1;
              end
            end else if (!second_q) begin
              // Leading whitespace counts as a zero digit.
              head.pre[0] = {4'h0, mtd_pkg::hex_value(in_byte_i)};
              head.pre_n  = 2'd1;
              phase_d     = PH_NONE;
            end else begin
              // Two whitespace digits make a zero byte, then the held whitespace
              // goes out literally, then this character unless it opens an escape.
              head.pre[0]     = 8'h00;
              head.pre_n      = 2'd1;
              space_n         = space_cnt_q;
              space_cnt_d     = '0;
              second_d        = 1'b0;
              head.post       = in_byte_i;
              head.post_valid = !is_pad;
              phase_d         = is_pad ? PH_EQ : PH_NONE;
            end
          end
        endcase
      end
      mtd_pkg::MODE_B64: begin
        if (!pad_done_q && (is_pad || !b64[6])) begin
          pad_count_d = pad_nx;
          if (group_count_q == 2'd3) begin
            head.pre[0]   = gb_nx[23:16];
            head.pre[1]   = gb_nx[15:8];
            head.pre[2]   = gb_nx[7:0];
            head.pre_n    = (pad_nx == 2'd0) ? 2'd3 : ((pad_nx == 2'd1) ? 2'd2 : 2'd1);
            group_bits_d  = '0;
            group_count_d = '0;
            if (pad_nx != 2'd0) pad_done_d = 1'b1;
          end else begin
            group_bits_d  = gb_nx;
            group_count_d = group_count_q + 2'd1;
          end
        end
      end
      mtd_pkg::MODE_OFF: begin
      end
    endcase

    head.last = in_last_i;
    if (in_last_i) begin
      phase_d       = PH_NONE;
      group_bits_d  = '0;
      group_count_d = '0;
      pad_count_d   = '0;
      pad_done_d    = 1'b0;
      second_d      = 1'b0;
      space_cnt_d   = '0;
    end
  end

  assign push_o    = accept && (head.pre_n != 2'd0 || space_n != '0 || head.post_valid ||
                                in_last_i);
  assign head_o    = head;
  assign spaces_o  = space_q;
  assign space_n_o = space_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_NONE;
      group_bits_q  <= '0;
      group_count_q <= '0;
      pad_count_q   <= '0;
      pad_done_q    <= 1'b0;
      first_q       <= '0;
      second_q      <= 1'b0;
      space_cnt_q   <= '0;
    end else if (accept) begin
      phase_q       <= phase_d;
      group_bits_q  <= group_bits_d;
      group_count_q <= group_count_d;
      pad_count_q   <= pad_count_d;
      pad_done_q    <= pad_done_d;
      first_q       <= first_d;
      second_q      <= second_d;
      space_cnt_q   <= space_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && store_we) begin
      space_q[space_cnt_q[AddrW-1:0]] <= in_byte_i;
    end
  end

endmodule

/* rtl/core/mtd_queue.sv */
// Two-entry job queue between the front and the back of the MIME transfer decoder.
// Generic in its entry width; no package dependency.
module mtd_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o
);

  logic [1:0][WIDTH-1:0] mem_q;
  logic                  wr_ptr_q, rd_ptr_q;
  logic [1:0]            count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i) rd_ptr_q <= !rd_ptr_q;
      if (push_i && !pop_i) count_q <= count_q + 2'd1;
      else if (pop_i && !push_i) count_q <= count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

/* rtl/core/mtd_back.sv */
// Back part of the MIME transfer decoder: walks one job at a time and sends
// its decoded bytes through a registered output stage. Uses mtd_pkg.
module mtd_back #(
  parameter int unsigned SPACE_DEPTH = 8,
  localparam int unsigned CntW  = $clog2(SPACE_DEPTH + 1),
  localparam int unsigned AddrW = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1,
  localparam int unsigned TotW  = $clog2(SPACE_DEPTH + 5)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        job_valid_i,
  input  mtd_pkg::job_head_t          head_i,
  input  logic [SPACE_DEPTH-1:0][7:0] spaces_i,
  input  logic [CntW-1:0]             space_n_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [7:0]                  out_byte_o,
  output logic                        out_byte_valid_o,
  output logic                        out_run_last_o,
  output logic                        out_end_o
);

  logic [TotW-1:0] idx_q;
  logic            out_valid_q;
  logic [7:0]      out_byte_q;
  logic            out_bv_q, out_run_q, out_end_q;

  logic [TotW-1:0] total, pre_n, sp_end, off;
  logic            load, last_res;
  logic [7:0]      sel_byte;

  assign pre_n    = TotW'(head_i.pre_n);
  assign sp_end   = pre_n + TotW'(space_n_i);
  assign total    = sp_end + TotW'(head_i.post_valid);
  assign off      = idx_q - pre_n;
  // A job with no bytes is a bare end-of-message marker: one result.
  assign last_res = (total == '0) || (idx_q == total - 1'b1);
  assign load     = job_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o    = load && last_res;

  always_comb begin
    if (total == '0) sel_byte = 8'h00;
    else if (idx_q < pre_n) sel_byte = head_i.pre[idx_q[1:0]];
    else if (idx_q < sp_end) sel_byte = spaces_i[off[AddrW-1:0]];
    else sel_byte = head_i.post;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= last_res ? '0 : idx_q + 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= sel_byte;
      out_bv_q   <= (total != '0);
      out_run_q  <= last_res;
      out_end_q  <= last_res && head_i.last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_byte_o       = out_byte_q;
  assign out_byte_valid_o = out_bv_q;
  assign out_run_last_o   = out_run_q;
  assign out_end_o        = out_end_q;

endmodule

/* rtl/core/mime_transfer_decoder_unit.sv */
// MIME transfer decoder (copy, quoted-printable, base64). The input side takes
// one encoded byte per clock whenever the two-entry job queue between the
// front and back parts has room; the back part sends one decoded word per
// clock while the output is not stalled, so a byte yields up to SPACE_DEPTH + 2
// results when a whitespace-escape closes, and a message end with no data
// yields one bare marker word. The first result of a byte passes through the
// job queue and then the registered output stage.
// decode_mode may only be written while idle.
// Top level; uses mtd_pkg, mtd_front, mtd_queue and mtd_back.
module mime_transfer_decoder_unit #(
  parameter int unsigned SPACE_DEPTH = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_data_i,     // decode_mode
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // message_end
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [1:0] m_axis_tuser,   // [0] byte_valid, [1] run_last
  output logic       m_axis_tlast    // end_flag
);

  localparam int unsigned CntW  = $clog2(SPACE_DEPTH + 1);
  localparam int unsigned HeadW = $bits(mtd_pkg::job_head_t);
  localparam int unsigned EntW  = HeadW + SPACE_DEPTH * 8 + CntW;

  mtd_pkg::mode_e              mode_q;
  logic                        push, pop, q_full, q_valid;
  mtd_pkg::job_head_t          f_head, b_head;
  logic [SPACE_DEPTH-1:0][7:0] f_spaces, b_spaces;
  logic [CntW-1:0]             f_space_n, b_space_n;
  logic [EntW-1:0]             q_in, q_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= mtd_pkg::MODE_COPY;
    end else if (cfg_valid_i) begin
      mode_q <= mtd_pkg::mode_e'(cfg_data_i);
    end
  end

  mtd_front #(.SPACE_DEPTH(SPACE_DEPTH)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (mode_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .queue_full_i (q_full),
    .push_o       (push),
    .head_o       (f_head),
    .spaces_o     (f_spaces),
    .space_n_o    (f_space_n)
  );

  assign q_in = {f_space_n, f_spaces, f_head};

  mtd_queue #(.WIDTH(EntW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .data_o  (q_out)
  );

  assign b_head    = q_out[HeadW-1:0];
  assign b_spaces  = q_out[HeadW + SPACE_DEPTH*8 - 1:HeadW];
  assign b_space_n = q_out[EntW-1:HeadW + SPACE_DEPTH*8];

  mtd_back #(.SPACE_DEPTH(SPACE_DEPTH)) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .job_valid_i      (q_valid),
    .head_i           (b_head),
    .spaces_i         (b_spaces),
    .space_n_i        (b_space_n),
    .pop_o            (pop),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_byte_o       (m_axis_tdata),
    .out_byte_valid_o (m_axis_tuser[0]),
    .out_run_last_o   (m_axis_tuser[1]),
    .out_end_o        (m_axis_tlast)
  );

endmodule

/* rtl/core/mtd_checker.sv */
// Port-level checks for mime_transfer_decoder_unit, attached by the bind below.
// Sees the top level's ports only; no package dependency.
module mtd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  // A stalled output word keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // The end of a message also ends the run of its last input byte.
  a_end_is_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[1])
    else $error("end of message without run end");

  // A word without data is only ever the bare end-of-message marker.
  a_bare_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |->
      m_axis_tlast && m_axis_tuser[1] && m_axis_tdata == 8'h00)
    else $error("bare marker malformed");

  // Nothing comes out in the cycle right after a reset release.
  a_quiet_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind mime_transfer_decoder_unit mtd_checker u_mtd_checker (.*);

/* test/mime_transfer_decoder_unit_tb.sv */
// Self-checking testbench for mime_transfer_decoder_unit: copy, quoted-printable and
// base64 messages go in, and every decoded word is checked against a built-in decoder.
// Depends on mtd_pkg and the decoder RTL only.
`timescale 1ns / 100ps

module mime_transfer_decoder_unit_tb;

  localparam int unsigned SPACE_DEPTH = 8;
  localparam int unsigned BURST_MAX = SPACE_DEPTH + 2;

  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,
    ESC_EQ    = 2'd1,
    ESC_DIGIT = 2'd2,
    ESC_SPACE = 2'd3
  } escape_e;

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       run_last;
    logic       end_flag;
  } decoded_word_t;

  // Decoder state mirror plus the queue of words still owed by the block.
  class mime_decode_board;
    mtd_pkg::mode_e mode;
    logic [23:0]    group_bits;
    int unsigned    group_count;
    int unsigned    pad_count;
    bit             padding_done;
    escape_e        escape_phase;
    logic [15:0]    hex_pair;
    logic [7:0]     space_store[SPACE_DEPTH];
    int unsigned    space_count;
    logic [7:0]     burst_q[$];
    decoded_word_t  expected_words[$];
    int             errors;

    function new();
      mode = mtd_pkg::MODE_COPY;
      errors = 0;
      clear_state();
    endfunction

    function void clear_state();
      group_bits = '0;
      group_count = 0;
      pad_count = 0;
      padding_done = 0;
      escape_phase = ESC_NONE;
      hex_pair = '0;
      space_count = 0;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void put(logic [7:0] b);
      if (burst_q.size() < BURST_MAX) burst_q.push_back(b);
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function logic [3:0] nibble(logic [7:0] c);
      if (c >= "0" && c <= "9") return 4'(c - "0");
      if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
      if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
      return 4'h0;
    endfunction

    // Bit 6 flags a character outside the alphabet.
    function logic [6:0] b64_code(logic [7:0] c);
      if (c >= "A" && c <= "Z") return 7'(c - "A");
      if (c >= "a" && c <= "z") return 7'(c - "a" + 26);
      if (c >= "0" && c <= "9") return 7'(c - "0" + 52);
      if (c == "+") return 7'(mtd_pkg::B64_PLUS);
      if (c == "/") return 7'(mtd_pkg::B64_SLASH);
      return 7'd64;
    endfunction

    function void qp_step(logic [7:0] b);
      int unsigned i;
      case (escape_phase)
        ESC_EQ: begin
          if (b == mtd_pkg::LF_CHAR) begin
            escape_phase = ESC_NONE;
          end else if (is_blank(b)) begin
            hex_pair = {b, 8'h00};
            space_count = 0;
            escape_phase = ESC_SPACE;
          end else begin
            hex_pair = {b, 8'h00};
            escape_phase = ESC_DIGIT;
          end
        end
        ESC_DIGIT: begin
          put({nibble(hex_pair[15:8]), nibble(b)});
          hex_pair = '0;
          escape_phase = ESC_NONE;
        end
        ESC_SPACE: begin
          if (b == mtd_pkg::LF_CHAR) begin
            hex_pair = '0;
            space_count = 0;
            escape_phase = ESC_NONE;
          end else if (is_blank(b)) begin
            if (hex_pair[7:0] == 8'h00) hex_pair[7:0] = b;
            else if (space_count < SPACE_DEPTH) begin
              space_store[space_count] = b;
              space_count++;
            end
          end else if (hex_pair[7:0] == 8'h00) begin
            put({4'h0, nibble(b)});
            hex_pair = '0;
            escape_phase = ESC_NONE;
          end else begin
            // Two blanks make a zero byte; the stored whitespace follows literally.
            put(8'h00);
            for (i = 0; i < space_count; i++) put(space_store[i]);
            space_count = 0;
            hex_pair = '0;
            escape_phase = ESC_NONE;
            if (b == mtd_pkg::EQ_CHAR) escape_phase = ESC_EQ;
            else put(b);
          end
        end
        default: begin
          if (b == mtd_pkg::EQ_CHAR) escape_phase = ESC_EQ;
          else put(b);
        end
      endcase
    endfunction

    function void b64_step(logic [7:0] b);
      logic [6:0] code;
      if (padding_done) return;
      if (b == mtd_pkg::EQ_CHAR) begin
        code = 7'd0;
        if (pad_count < 3) pad_count++;
      end else begin
        code = b64_code(b);
        if (code[6]) return;
      end
      group_bits = {group_bits[17:0], code[5:0]};
      group_count++;
      if (group_count == 4) begin
        put(group_bits[23:16]);
        if (pad_count < 2) put(group_bits[15:8]);
        if (pad_count < 1) put(group_bits[7:0]);
        group_bits = '0;
        group_count = 0;
        if (pad_count != 0) padding_done = 1;
      end
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      decoded_word_t w;
      bit bare;
      int unsigned k;
      bare = 0;
      burst_q.delete();
      case (mode)
        mtd_pkg::MODE_COPY: put(b);
        mtd_pkg::MODE_QP:   qp_step(b);
        mtd_pkg::MODE_B64:  b64_step(b);
        default:            ;
      endcase
      if (last) begin
        if (burst_q.size() == 0) begin
          bare = 1;
          burst_q.push_back(8'h00);
        end
        clear_state();
      end
      for (k = 0; k < burst_q.size(); k++) begin
        w.data = burst_q[k];
        w.byte_valid = !bare;
        w.run_last = (k + 1 == burst_q.size());
        w.end_flag = last && (k + 1 == burst_q.size());
        expected_words.push_back(w);
      end
    endfunction

    function void check_word(logic [7:0] data, logic bvalid, logic rlast, logic eflag);
      decoded_word_t w;
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: data %h valid %b run_last %b end %b",
                 $time, data, bvalid, rlast, eflag);
        return;
      end
      w = expected_words.pop_front();
      if (w.data !== data || w.byte_valid !== bvalid || w.run_last !== rlast ||
          w.end_flag !== eflag) begin
        errors++;
        $display("%0t: expected data %h valid %b run_last %b end %b, got %h %b %b %b",
                 $time, w.data, w.byte_valid, w.run_last, w.end_flag,
                 data, bvalid, rlast, eflag);
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_data_i = 2'd0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // [7:0] in_byte
  logic       s_axis_tlast = 1'b0;    // message_end
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] out_byte
  logic [1:0] m_axis_tuser;           // [0] byte_valid, [1] run_last
  logic       m_axis_tlast;           // end_flag

  mime_decode_board board = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic [8:0] feed_q[$];              // {message_end, in_byte}

  mime_transfer_decoder_unit #(.SPACE_DEPTH(SPACE_DEPTH)) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_word(m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1], m_axis_tlast);
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  task automatic set_idling(input int unsigned phase);
    case (phase)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
      default: begin send_idle_pct = 27; recv_stall_pct = 27; end
    endcase
  endtask

  task automatic write_mode(input mtd_pkg::mode_e m);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    board.mode = m;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_byte(b, last);
  endtask

  task automatic send_all();
    logic [8:0] w;
    while (feed_q.size() != 0) begin
      w = feed_q.pop_front();
      send_byte(w[7:0], w[8]);
    end
  endtask

  // Waits until every owed word is out, then covers a byte still in flight
  // that yields nothing.
  task automatic idle_wait();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
    repeat (12) @(posedge clk_i);
  endtask

  function automatic void add(input logic [7:0] b);
    feed_q.push_back({1'b0, b});
  endfunction

  function automatic void end_message();
    feed_q[feed_q.size() - 1][8] = 1'b1;
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    c = 8'($urandom_range(33, 126));
    return (c == mtd_pkg::EQ_CHAR) ? "Z" : c;
  endfunction

  function automatic logic [7:0] blank_char();
    logic [7:0] blanks[5];
    blanks = '{8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D};
    return blanks[$urandom_range(4)];
  endfunction

  function automatic logic [7:0] hex_char();
    string digits;
    digits = "0123456789abcdefABCDEF";
    return digits[$urandom_range(21)];
  endfunction

  function automatic logic [7:0] b64_char();
    int unsigned v;
    v = $urandom_range(63);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    return (v == 62) ? "+" : "/";
  endfunction

  function automatic void add_qp_token();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(99);
    if (r < 40) begin
      add(plain_char());
    end else if (r < 58) begin
      add(mtd_pkg::EQ_CHAR); add(hex_char()); add(hex_char());
    end else if (r < 66) begin
      // Soft line break, possibly with trailing blanks.
      add(mtd_pkg::EQ_CHAR);
      n = $urandom_range(2);
      repeat (n) add(blank_char());
      add(mtd_pkg::LF_CHAR);
    end else if (r < 73) begin
      add(mtd_pkg::EQ_CHAR); add(blank_char()); add(plain_char());
    end else if (r < 83) begin
      // Long whitespace run after the escape; may overflow the blank store.
      add(mtd_pkg::EQ_CHAR);
      n = $urandom_range(2, 11);
      repeat (n) add(blank_char());
      add($urandom_range(1) ? mtd_pkg::EQ_CHAR : plain_char());
    end else if (r < 89) begin
      add(mtd_pkg::EQ_CHAR); add(plain_char()); add(8'($urandom_range(255)));
    end else begin
      add(8'($urandom_range(255)));
    end
  endfunction

  function automatic void add_b64_message();
    int unsigned groups;
    int unsigned n;
    groups = $urandom_range(1, 4);
    repeat (groups) begin
      repeat (4) begin
        if ($urandom_range(9) == 0)
          add($urandom_range(1) ? mtd_pkg::LF_CHAR : 8'($urandom_range(255)));
        add(b64_char());
      end
    end
    case ($urandom_range(5))
      0: begin
        add(b64_char()); add(b64_char()); add(mtd_pkg::EQ_CHAR); add(mtd_pkg::EQ_CHAR);
      end
      1: begin
        add(b64_char()); add(b64_char()); add(b64_char()); add(mtd_pkg::EQ_CHAR);
      end
      2: begin
        add(b64_char()); add(mtd_pkg::EQ_CHAR); add(mtd_pkg::EQ_CHAR);
        add(mtd_pkg::EQ_CHAR);
      end
      3: begin n = $urandom_range(1, 3); repeat (n) add(b64_char()); end
      default: ;
    endcase
    // Characters after the padding must be ignored.
    if ($urandom_range(3) == 0) begin
      add(b64_char()); add(mtd_pkg::EQ_CHAR); add(b64_char());
    end
    end_message();
  endfunction

  function automatic void add_message(input mtd_pkg::mode_e m);
    int unsigned n;
    case (m)
      mtd_pkg::MODE_QP: begin
        n = $urandom_range(1, 6);
        repeat (n) add_qp_token();
        end_message();
      end
      mtd_pkg::MODE_B64: add_b64_message();
      default: begin
        n = $urandom_range(1, 8);
        repeat (n) add(8'($urandom_range(255)));
        end_message();
      end
    endcase
  endfunction

  initial begin
    mtd_pkg::mode_e phase_modes[8];
    int unsigned p;
    phase_modes = '{mtd_pkg::MODE_COPY, mtd_pkg::MODE_QP, mtd_pkg::MODE_B64,
                    mtd_pkg::MODE_OFF, mtd_pkg::MODE_QP, mtd_pkg::MODE_B64,
                    mtd_pkg::MODE_QP, mtd_pkg::MODE_B64};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: byte extremes, every mode and the escape corner cases.
    write_mode(mtd_pkg::MODE_COPY);
    add(8'h00); add(8'hFF); end_message();
    send_all();
    idle_wait();
    write_mode(mtd_pkg::MODE_QP);
    add(mtd_pkg::EQ_CHAR); add("4"); add("f");
    add(mtd_pkg::EQ_CHAR); add("G"); add(mtd_pkg::LF_CHAR);
    add(mtd_pkg::EQ_CHAR); add(mtd_pkg::SP_CHAR); add(mtd_pkg::LF_CHAR);
    add(mtd_pkg::EQ_CHAR); add(mtd_pkg::SP_CHAR); add("c");
    add(mtd_pkg::EQ_CHAR); add(mtd_pkg::SP_CHAR); add(mtd_pkg::SP_CHAR); add(8'h09);
    add(mtd_pkg::EQ_CHAR); add("x");
    send_all();
    // The escape stays open across the switch to base64.
    idle_wait();
    write_mode(mtd_pkg::MODE_B64);
    add("Q"); add("U"); add("J"); add(mtd_pkg::EQ_CHAR); add("Z"); end_message();
    send_all();
    idle_wait();
    write_mode(mtd_pkg::MODE_OFF);
    add("A"); end_message();
    send_all();

    for (p = 0; p < 8; p++) begin
      idle_wait();
      set_idling(p % 4);
      write_mode(phase_modes[p]);
      while (feed_q.size() < 13) add_message(phase_modes[p]);
      send_all();
    end

    idle_wait();
    repeat (16) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
